>>> sv/tspe_pkg.sv
// Shared types and constants of the transport stream PES payload extractor.
`default_nettype none
package tspe_pkg;

   localparam int PID_W = 13;

   localparam logic [7:0] SYNC_MARK  = 8'h47;
   localparam logic [7:0] PACKET_LEN = 8'd188;
   localparam logic [7:0] LAST_POS   = 8'd187;
   localparam logic [7:0] HEADER_LEN = 8'd4;
   localparam logic [7:0] ADAPT_MAX  = 8'd183;

   localparam logic [8:0] NONE_OFS       = 9'h1FF;
   localparam logic [8:0] PES_FIXED_LEN  = 9'd9;
   localparam logic [8:0] START_CODE_LEN = 9'd3;
   localparam logic [8:0] START_CODE_END = 9'd2;
   localparam logic [8:0] HDR_LEN_IDX    = 9'd8;

   localparam logic [1:0] ADAPT_RESERVED = 2'd0;
   localparam logic [1:0] ADAPT_PAYLOAD  = 2'd1;
   localparam logic [1:0] ADAPT_ONLY     = 2'd2;
   localparam logic [1:0] ADAPT_BOTH     = 2'd3;

   typedef struct packed {
      logic [7:0] es_byte;
      logic       es_valid;
      logic       es_first;
      logic       packet_end;
      logic       sync_error;
      logic       start_code_error;
      logic       adaptation_overflow;
   } tspe_result_type;

endpackage
`default_nettype wire

>>> sv/tspe_parser.sv
// Packet header parser, PES header stripper and target PID filter.
`default_nettype none
module tspe_parser (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         take,
   input  wire logic [7:0]                   ts_byte,
   input  wire logic                         packet_first,
   input  wire logic                         csr_we,
   input  wire logic [tspe_pkg::PID_W-1:0]   csr_wdata,
   output tspe_pkg::tspe_result_type         result
);
   import tspe_pkg::*;

   logic [PID_W-1:0] target_pid_ff;
   logic [7:0]       byte_pos_ff, byte_pos_in;
   logic [PID_W-1:0] pid_ff, pid_in;
   logic [1:0]       adapt_ff, adapt_in;
   logic             unit_start_ff, unit_start_in;
   logic [8:0]       pes_ofs_ff, pes_ofs_in;
   logic [8:0]       es_ofs_ff, es_ofs_in;
   logic             sc_bad_ff, sc_bad_in;

   logic [7:0] pos;
   logic       active;
   logic [7:0] q;
   logic [8:0] q9;
   logic [8:0] r;
   logic       tgt;
   logic [7:0] expect_byte;

   always_comb begin
      byte_pos_in   = byte_pos_ff;
      pid_in        = pid_ff;
      adapt_in      = adapt_ff;
      unit_start_in = unit_start_ff;
      pes_ofs_in    = pes_ofs_ff;
      es_ofs_in     = es_ofs_ff;
      sc_bad_in     = sc_bad_ff;
      result        = '0;
      pos           = '0;
      active        = 1'b1;
      q             = '0;
      q9            = '0;
      r             = '0;
      expect_byte   = '0;
      tgt           = (pid_ff == target_pid_ff);

      if (packet_first) begin
         pos = '0;
      end else if (byte_pos_ff == 8'd0 || byte_pos_ff >= PACKET_LEN) begin
         active = 1'b0;
      end else begin
         pos = byte_pos_ff;
      end
      q  = pos - HEADER_LEN;
      q9 = {1'b0, q};

      if (active) begin
         byte_pos_in       = pos + 8'd1;
         result.packet_end = (pos == LAST_POS);
         if (pos == 8'd0) begin
            result.sync_error = (ts_byte != SYNC_MARK);
            pid_in            = '0;
            adapt_in          = '0;
            unit_start_in     = 1'b0;
            pes_ofs_in        = NONE_OFS;
            es_ofs_in         = NONE_OFS;
            sc_bad_in         = 1'b0;
         end else if (pos == 8'd1) begin
            unit_start_in = ts_byte[6];
            pid_in        = {ts_byte[4:0], 8'h00};
         end else if (pos == 8'd2) begin
            pid_in = pid_ff | {5'd0, ts_byte};
         end else if (pos == 8'd3) begin
            adapt_in = ts_byte[5:4];
            if (ts_byte[5:4] == ADAPT_PAYLOAD) begin
               pes_ofs_in = '0;
               es_ofs_in  = unit_start_ff ? NONE_OFS : 9'd0;
            end
         end else begin
            if (tgt && adapt_ff[1] && q == 8'd0) begin
               if (ts_byte > ADAPT_MAX) begin
                  result.adaptation_overflow = 1'b1;
               end else if (adapt_ff == ADAPT_BOTH) begin
                  pes_ofs_in = {1'b0, ts_byte} + 9'd1;
                  if (!unit_start_ff) begin
                     es_ofs_in = {1'b0, ts_byte} + 9'd1;
                  end
               end
            end else if (tgt && unit_start_ff && pes_ofs_ff != NONE_OFS
                         && q9 >= pes_ofs_ff && es_ofs_ff == NONE_OFS && !sc_bad_ff) begin
               r = q9 - pes_ofs_ff;
               if (r < START_CODE_LEN) begin
                  expect_byte = (r == START_CODE_END) ? 8'd1 : 8'd0;
                  if (ts_byte != expect_byte) begin
                     sc_bad_in = 1'b1;
                  end
                  if (r == START_CODE_END && (sc_bad_ff || ts_byte != expect_byte)) begin
                     result.start_code_error = 1'b1;
                  end
               end else if (r == HDR_LEN_IDX) begin
                  es_ofs_in = pes_ofs_ff + PES_FIXED_LEN + {1'b0, ts_byte};
               end
            end
            if (tgt && es_ofs_in != NONE_OFS && q9 >= es_ofs_in) begin
               result.es_valid = 1'b1;
               result.es_byte  = ts_byte;
               result.es_first = unit_start_ff && (q9 == es_ofs_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_pid_ff <= '0;
      end else if (csr_we) begin
         target_pid_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff   <= '0;
         pid_ff        <= '0;
         adapt_ff      <= '0;
         unit_start_ff <= 1'b0;
         pes_ofs_ff    <= NONE_OFS;
         es_ofs_ff     <= NONE_OFS;
         sc_bad_ff     <= 1'b0;
      end else if (take) begin
         byte_pos_ff   <= byte_pos_in;
         pid_ff        <= pid_in;
         adapt_ff      <= adapt_in;
         unit_start_ff <= unit_start_in;
         pes_ofs_ff    <= pes_ofs_in;
         es_ofs_ff     <= es_ofs_in;
         sc_bad_ff     <= sc_bad_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/tspe_out_reg.sv
// Result register of the extractor with its output handshake.
`default_nettype none
module tspe_out_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire tspe_pkg::tspe_result_type result_in,
   input  wire logic                      rsp_tready,
   output logic                           rsp_tvalid,
   output logic                           room,
   output tspe_pkg::tspe_result_type      result_out
);
   import tspe_pkg::*;

   logic            valid_ff;
   tspe_result_type result_ff;

   assign room       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign result_out = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/ts_pes_payload_extractor_unit.sv
// Top level of the transport stream PES payload extractor.
// The result item is registered and appears on the rsp side in the cycle after its input item is accepted.
// Throughput: one item per cycle while rsp_tready is high; the single result register sets the pace.
// Reset: synchronous, active high; clears packet state, target PID and the result valid flag.
`default_nettype none
module ts_pes_payload_extractor_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] stream byte
   input  wire logic        req_tuser,   // [0] packet_first
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] es_byte
   output logic [4:0]       rsp_tuser,   // [0] es_valid, [1] es_first, [2] sync_error,
                                         // [3] start_code_error, [4] adaptation_overflow
   output logic             rsp_tlast,   // packet_end
   input  wire logic        csr_we,
   input  wire logic [12:0] csr_wdata    // target_pid
);
   import tspe_pkg::*;

   logic            take;
   logic            room;
   tspe_result_type result;
   tspe_result_type result_q;

   assign req_tready = room;
   assign take       = req_tvalid && room;

   tspe_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .ts_byte      (req_tdata),
      .packet_first (req_tuser),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .result       (result)
   );

   tspe_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .result_in  (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .room       (room),
      .result_out (result_q)
   );

   assign rsp_tdata = result_q.es_byte;
   assign rsp_tlast = result_q.packet_end;
   assign rsp_tuser = {result_q.adaptation_overflow, result_q.start_code_error,
                       result_q.sync_error, result_q.es_first, result_q.es_valid};

endmodule
`default_nettype wire

>>> sv/tspe_checker.sv
// Port-level checks of the extractor and their bind to the top level.
`default_nettype none
module tspe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic [4:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import tspe_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   a_first_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("es_first without es_valid");

   a_no_byte_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[2] && !rsp_tuser[3] && !rsp_tuser[4])
      else $error("payload byte passed with an error flag");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("nonzero es_byte without es_valid");

   a_sync_flag: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser && req_tdata != SYNC_MARK
         |=> rsp_tvalid && rsp_tuser[2])
      else $error("bad sync byte not flagged");

endmodule

bind ts_pes_payload_extractor_unit tspe_checker u_tspe_checker (.*);
`default_nettype wire
